### src/matrix4x4_multiply_unit_defines.svh
// assertion macros used by the port-level checker of the matrix multiply unit
`ifndef MATRIX4X4_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_UNIT_DEFINES_SVH

// same-cycle implication
`define MMU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MMU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/mmu_pkg.sv
// shared constants and types of the matrix multiply unit
`default_nettype none
package mmu_pkg;
    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 2;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + $clog2(DIM);

    typedef struct packed {
        logic                    v;
        logic [IDX_W-1:0]        i;
        logic [IDX_W-1:0]        j;
        logic signed [SUM_W-1:0] sum;
    } t_link;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;
endpackage
`default_nettype wire

### src/mmu_cell.sv
// one multiply-accumulate cell holding a column of L and a row of R
`default_nettype none
module mmu_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_l,
    input  wire logic                          i_wr_r,
    input  wire logic [mmu_pkg::IDX_W-1:0]     i_wr_addr,
    input  wire logic [mmu_pkg::DATA_W-1:0]    i_wr_data,
    input  wire mmu_pkg::t_link                i_link,
    output mmu_pkg::t_link                     o_link
);
    logic signed [mmu_pkg::DATA_W-1:0] r_l [mmu_pkg::DIM];
    logic signed [mmu_pkg::DATA_W-1:0] r_r [mmu_pkg::DIM];
    logic signed [mmu_pkg::PROD_W-1:0] r_prod;
    mmu_pkg::t_link                    r_a;
    mmu_pkg::t_link                    r_b;
    mmu_pkg::t_link                    n_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < mmu_pkg::DIM; n++) begin
                r_l[n] <= '0;
                r_r[n] <= '0;
            end
        end else begin
            if (i_wr_l) begin
                r_l[i_wr_addr] <= i_wr_data;
            end
            if (i_wr_r) begin
                r_r[i_wr_addr] <= i_wr_data;
            end
        end
    end

    always_comb begin
        n_b     = r_a;
        n_b.sum = r_a.sum + mmu_pkg::SUM_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_l[i_link.i] * r_r[i_link.j];
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
        end else begin
            r_a <= i_link;
            r_b <= n_b;
        end
    end

    assign o_link = r_b;
endmodule
`default_nettype wire

### src/mmu_sat.sv
// floor shift, saturation and output register
`default_nettype none
module mmu_sat (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mmu_pkg::t_link             i_link,
    output logic                            o_valid,
    output logic [mmu_pkg::IDX_W-1:0]       o_row,
    output logic [mmu_pkg::IDX_W-1:0]       o_col,
    output logic signed [mmu_pkg::DATA_W-1:0] o_value,
    output logic                            o_last
);
    localparam logic signed [mmu_pkg::SUM_W-1:0] Q_MAX =
        {{(mmu_pkg::SUM_W-32){1'b0}}, 32'h7fff_ffff};
    localparam logic signed [mmu_pkg::SUM_W-1:0] Q_MIN =
        {{(mmu_pkg::SUM_W-32){1'b1}}, 32'h8000_0000};

    logic signed [mmu_pkg::SUM_W-1:0]  w_q;
    logic signed [mmu_pkg::DATA_W-1:0] n_value;
    logic                              r_valid;
    logic [mmu_pkg::IDX_W-1:0]         r_row;
    logic [mmu_pkg::IDX_W-1:0]         r_col;
    logic signed [mmu_pkg::DATA_W-1:0] r_value;
    logic                              r_last;

    assign w_q = i_link.sum >>> mmu_pkg::FRAC_BITS;

    always_comb begin
        if (w_q > Q_MAX) begin
            n_value = Q_MAX[mmu_pkg::DATA_W-1:0];
        end else if (w_q < Q_MIN) begin
            n_value = Q_MIN[mmu_pkg::DATA_W-1:0];
        end else begin
            n_value = w_q[mmu_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= i_link.i;
        r_col   <= i_link.j;
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_last  <= i_link.v && (i_link.i == mmu_pkg::IDX_W'(mmu_pkg::DIM - 1))
                       && (i_link.j == mmu_pkg::IDX_W'(mmu_pkg::DIM - 1));
            r_valid <= i_link.v;
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_value = r_value;
    assign o_last  = r_last;
endmodule
`default_nettype wire

### src/matrix4x4_multiply_unit.sv
// top level: element loader, index sequencer and chain of MAC cells
// a load beat is taken while idle; busy stays low throughout
// a compute beat holds busy high through the issue and drain states, until the last result
// results stream on consecutive cycles out of the output register, behind the two registers of each cell
// the rate is set by one (i,j) issue per cycle through the cell chain
// synchronous reset clears both matrices to zero and idles the sequencer
`default_nettype none
module matrix4x4_multiply_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_which_matrix,
    input  wire logic [1:0]                    i_row_index,
    input  wire logic [1:0]                    i_col_index,
    input  wire logic signed [31:0]            i_element_value,
    input  wire logic                          i_compute_now,
    output logic                               o_valid,
    output logic [1:0]                         o_out_row,
    output logic [1:0]                         o_out_col,
    output logic signed [31:0]                 o_product_value,
    output logic                               o_last_element
);
    mmu_pkg::t_state           r_state;
    mmu_pkg::t_state           n_state;
    logic [mmu_pkg::IDX_W-1:0] r_i;
    logic [mmu_pkg::IDX_W-1:0] r_j;
    logic [mmu_pkg::IDX_W-1:0] n_i;
    logic [mmu_pkg::IDX_W-1:0] n_j;
    logic                      w_acc;
    logic                      w_in_range;
    logic                      w_last_issue;
    mmu_pkg::t_link            w_link [mmu_pkg::DIM+1];

    assign w_acc        = start && !busy;
    assign w_in_range   = (32'(i_row_index) < mmu_pkg::DIM) && (32'(i_col_index) < mmu_pkg::DIM);
    assign w_last_issue = (r_i == mmu_pkg::IDX_W'(mmu_pkg::DIM - 1))
                          && (r_j == mmu_pkg::IDX_W'(mmu_pkg::DIM - 1));
    assign busy         = (r_state != mmu_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        case (r_state)
            mmu_pkg::ST_IDLE: begin
                n_i = '0;
                n_j = '0;
                if (w_acc && i_compute_now) begin
                    n_state = mmu_pkg::ST_ISSUE;
                end
            end
            mmu_pkg::ST_ISSUE: begin
                if (r_j == mmu_pkg::IDX_W'(mmu_pkg::DIM - 1)) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                if (w_last_issue) begin
                    n_state = mmu_pkg::ST_DRAIN;
                end
            end
            mmu_pkg::ST_DRAIN: begin
                if (o_valid && o_last_element) begin
                    n_state = mmu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mmu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmu_pkg::ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_comb begin
        w_link[0].v   = (r_state == mmu_pkg::ST_ISSUE);
        w_link[0].i   = r_i;
        w_link[0].j   = r_j;
        w_link[0].sum = '0;
    end

    for (genvar k = 0; k < mmu_pkg::DIM; k++) begin : g_cell
        logic                      w_wr_l;
        logic                      w_wr_r;
        logic [mmu_pkg::IDX_W-1:0] w_addr;

        assign w_wr_l = w_acc && w_in_range && !i_which_matrix
                        && (i_col_index == mmu_pkg::IDX_W'(k));
        assign w_wr_r = w_acc && w_in_range && i_which_matrix
                        && (i_row_index == mmu_pkg::IDX_W'(k));
        assign w_addr = i_which_matrix ? i_col_index : i_row_index;

        mmu_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_l    (w_wr_l),
            .i_wr_r    (w_wr_r),
            .i_wr_addr (w_addr),
            .i_wr_data (i_element_value),
            .i_link    (w_link[k]),
            .o_link    (w_link[k+1])
        );
    end

    mmu_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_link[mmu_pkg::DIM]),
        .o_valid (o_valid),
        .o_row   (o_out_row),
        .o_col   (o_out_col),
        .o_value (o_product_value),
        .o_last  (o_last_element)
    );
endmodule
`default_nettype wire

### src/mmu_checker.sv
// port-level checker for the matrix multiply unit and its bind
`default_nettype none
`include "matrix4x4_multiply_unit_defines.svh"
module mmu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        i_compute_now,
    input wire logic        o_valid,
    input wire logic [1:0]  o_out_row,
    input wire logic        o_last_element
);
    `MMU_ASSERT_NEXT(a_compute_busy, start && !busy && i_compute_now, busy)
    `MMU_ASSERT_NEXT(a_load_idle, start && !busy && !i_compute_now, !busy)
    `MMU_ASSERT_NOW(a_valid_busy, o_valid, busy)
    `MMU_ASSERT_NOW(a_last_valid, o_last_element, o_valid && o_out_row == 2'd3)
    `MMU_ASSERT_NEXT(a_stream, o_valid && !o_last_element, o_valid)
endmodule

bind matrix4x4_multiply_unit mmu_checker u_mmu_checker (.*);
`default_nettype wire

### verif/matrix4x4_multiply_unit_checker.sv
// checker for the matrix multiply unit: predicts each product beat and compares it
`timescale 1ns / 1ps
module matrix4x4_multiply_unit_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic        i_which_matrix,
    input  wire logic [1:0]  i_row_index,
    input  wire logic [1:0]  i_col_index,
    input  wire logic [31:0] i_element_value,
    input  wire logic        i_compute_now,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_out_row,
    input  wire logic [1:0]  i_out_col,
    input  wire logic [31:0] i_product_value,
    input  wire logic        i_last_element,
    output int               o_errors,
    output int               o_pending
);
    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        last;
    } t_elem;

    logic signed [31:0] left_m [mmu_pkg::DIM*mmu_pkg::DIM];
    logic signed [31:0] right_m [mmu_pkg::DIM*mmu_pkg::DIM];
    t_elem              product_q[$];

    function automatic logic [31:0] dot_sat(int i, int j);
        logic signed [mmu_pkg::SUM_W-1:0] acc;
        logic signed [mmu_pkg::SUM_W-1:0] q;
        acc = '0;
        for (int k = 0; k < mmu_pkg::DIM; k++)
            acc += mmu_pkg::SUM_W'(left_m[i*mmu_pkg::DIM+k])
                   * mmu_pkg::SUM_W'(right_m[k*mmu_pkg::DIM+j]);
        q = acc >>> mmu_pkg::FRAC_BITS;
        if (q > mmu_pkg::SUM_W'(32'sh7fffffff))
            return 32'h7fffffff;
        if (q < -mmu_pkg::SUM_W'(33'sh080000000))
            return 32'h80000000;
        return q[31:0];
    endfunction

    always @(posedge i_clk) begin
        t_elem exp_e;
        if (!i_rst_n) begin
            for (int n = 0; n < mmu_pkg::DIM*mmu_pkg::DIM; n++) begin
                left_m[n]  = '0;
                right_m[n] = '0;
            end
            product_q.delete();
            o_errors <= 0;
        end else begin
            if (i_valid) begin
                if (product_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("unexpected beat row %0d col %0d val %h",
                                 i_out_row, i_out_col, i_product_value);
                end else begin
                    exp_e = product_q.pop_front();
                    if (exp_e != {i_out_row, i_out_col, i_product_value, i_last_element}) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch exp %0d,%0d %h l%0b got %0d,%0d %h l%0b",
                                     exp_e.row, exp_e.col, exp_e.value, exp_e.last,
                                     i_out_row, i_out_col, i_product_value,
                                     i_last_element);
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_which_matrix)
                    right_m[i_row_index*mmu_pkg::DIM+i_col_index] = i_element_value;
                else
                    left_m[i_row_index*mmu_pkg::DIM+i_col_index] = i_element_value;
                if (i_compute_now)
                    for (int i = 0; i < mmu_pkg::DIM; i++)
                        for (int j = 0; j < mmu_pkg::DIM; j++)
                            product_q.push_back({2'(i), 2'(j), dot_sat(i, j),
                                                 i == mmu_pkg::DIM-1 && j == mmu_pkg::DIM-1});
            end
        end
    end

    assign o_pending = product_q.size();
endmodule

### verif/tb_matrix4x4_multiply_unit.sv
// testbench top for the matrix multiply unit: stimulus, idling phases and verdict
`timescale 1ns / 1ps
module tb_matrix4x4_multiply_unit;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_which_matrix = 0;
    logic [1:0]  i_row_index = 0;
    logic [1:0]  i_col_index = 0;
    logic [31:0] i_element_value = 0;
    logic        i_compute_now = 0;
    logic        o_valid;
    logic [1:0]  o_out_row;
    logic [1:0]  o_out_col;
    logic [31:0] o_product_value;
    logic        o_last_element;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          idle_pct = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    matrix4x4_multiply_unit uut (.*);

    matrix4x4_multiply_unit_checker chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_which_matrix,
        .i_row_index, .i_col_index, .i_element_value, .i_compute_now,
        .i_valid(o_valid), .i_out_row(o_out_row), .i_out_col(o_out_col),
        .i_product_value(o_product_value), .i_last_element(o_last_element),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(($urandom_range(0, 1) ? -1 : 1) * $urandom_range(0, 32'h3ffff));
            3: return 32'hffffffff;
            4: return 32'h00010000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(logic sel, logic [1:0] r, logic [1:0] c, logic [31:0] v,
                             logic go);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start           <= 1;
        i_which_matrix  <= sel;
        i_row_index     <= r;
        i_col_index     <= c;
        i_element_value <= v;
        i_compute_now   <= go;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    initial begin
        int phase;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty product, extremes, overflow both ways, identity-like
        send_beat(0, 0, 0, 0, 1);
        for (int k = 0; k < 4; k++) begin
            send_beat(0, 0, 2'(k), 32'h7fffffff, 0);
            send_beat(1, 2'(k), 0, 32'h7fffffff, 0);
        end
        send_beat(1, 3, 3, 32'h80000000, 1);
        for (int k = 0; k < 4; k++)
            send_beat(1, 2'(k), 0, 32'h80000000, 0);
        send_beat(0, 3, 3, 32'hffffffff, 1);
        send_beat(1, 0, 1, 32'h00010000, 1);
        send_beat(0, 1, 1, 32'hfffe8000, 1);
        for (int n = 0; n < 280; n++) begin
            phase = n / 70;
            idle_pct = phase == 1 ? 67 : phase == 3 ? 35 : 0;
            send_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      2'($urandom_range(0, 3)), pick_value(), $urandom_range(0, 7) == 0);
        end
        start <= 0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
